/* hw/rtl/ffpa_pkg.sv */
package ffpa_pkg;

    localparam int DEF_PAGE_COUNT = 64;
    localparam int DEF_ID_BITS    = 8;

    localparam int FUNC_W      = 3;
    localparam int ALLOC_ID_W  = 8;
    localparam int REQ_W       = 7;
    localparam int NEW_ID_W    = 8;
    localparam int CFG_PAGES_W = 7;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_PAGES_W-1:0] PAGES_IN_USE_RESET = 7'd64;

    // register index, taken from paddr above the byte lane bits
    localparam logic REG_PAGES_IN_USE = 1'b0;

    localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET_VALID = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLR_VALID = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY     = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [ALLOC_ID_W-1:0] alloc_id;
        logic [REQ_W-1:0]      req_pages;
    } t_in;

    typedef struct packed {
        logic [NEW_ID_W-1:0] new_id;
        logic                ok;
        logic                first_valid;
        logic                id_exists;
        logic [REQ_W-1:0]    recorded_size;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic fill;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic scan_end;
        logic hit;
        logic fill_last;
    } t_stat;

endpackage

/* hw/rtl/ffpa_ctrl.sv */
module ffpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ffpa_pkg::t_stat i_stat,
    output ffpa_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    ffpa_pkg::t_state r_state;
    ffpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            ffpa_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ffpa_pkg::ST_IDLE;
                end
            end
            ffpa_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ffpa_pkg::ST_SCAN;
                end
            end
            ffpa_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = i_stat.hit ? ffpa_pkg::ST_FILL : ffpa_pkg::ST_DONE;
                end
            end
            ffpa_pkg::ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = ffpa_pkg::ST_DONE;
                end
            end
            ffpa_pkg::ST_DONE: begin
                o_done  = 1'b1;
                n_state = ffpa_pkg::ST_IDLE;
            end
            default: begin
                n_state = ffpa_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

/* hw/rtl/ffpa_dp.sv */
module ffpa_dp #(
    parameter int PAGE_COUNT = ffpa_pkg::DEF_PAGE_COUNT,
    parameter int ID_BITS    = ffpa_pkg::DEF_ID_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ffpa_pkg::t_cmd                      i_cmd,
    output ffpa_pkg::t_stat                     o_stat,
    input  ffpa_pkg::t_in                       i_item,
    input  logic [ffpa_pkg::CFG_PAGES_W-1:0]    i_pages_in_use,
    output ffpa_pkg::t_out                      o_result
);

    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int CNT_W  = $clog2(PAGE_COUNT + 1);
    localparam int LW     = (CNT_W > ffpa_pkg::REQ_W) ? CNT_W : ffpa_pkg::REQ_W;
    localparam int ID_N   = 1 << ID_BITS;
    localparam int IDX_W  = (ID_BITS > ffpa_pkg::NEW_ID_W) ? ID_BITS : ffpa_pkg::NEW_ID_W;
    localparam int CLR_N  = (PAGE_COUNT > ID_N) ? PAGE_COUNT : ID_N;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int ENT_W  = ID_BITS + 1;

    // page entry: valid mark above the owner tag
    logic [ENT_W-1:0]           r_page_mem [PAGE_COUNT];
    logic [ffpa_pkg::REQ_W-1:0] r_size_mem [ID_N];

    logic [ffpa_pkg::FUNC_W-1:0] r_func;
    logic [ID_BITS-1:0]          r_id;
    logic [ffpa_pkg::REQ_W-1:0]  r_req;
    logic [ID_BITS-1:0]          r_aid;
    logic [ID_BITS-1:0]          r_next_id;
    logic [CNT_W-1:0]            r_len;
    logic [CNT_W-1:0]            r_idx;
    logic                        r_pend;
    logic [PAGE_W-1:0]           r_rd_idx;
    logic [ENT_W-1:0]            r_rd_ent;
    logic                        r_in_run;
    logic [PAGE_W-1:0]           r_run_start;
    logic [LW-1:0]               r_run_len;
    logic [PAGE_W-1:0]           r_fill_idx;
    logic [LW-1:0]               r_fill_cnt;
    logic                        r_ok;
    logic                        r_fv;
    logic                        r_ex;
    logic [ffpa_pkg::REQ_W-1:0]  r_size_rd;
    logic [CLR_W-1:0]            r_clr;

    logic [IDX_W-1:0]   w_id_ext;
    logic [ID_BITS-1:0] w_in_id;
    logic [IDX_W-1:0]   w_aid_ext;
    logic [CNT_W-1:0]   w_len;
    logic               w_issue;
    logic [ID_BITS-1:0] w_tag;
    logic               w_vld;
    logic               w_active;
    logic               w_match;
    logic               w_free;
    logic               w_is_alloc;
    logic               w_is_query;
    logic [LW-1:0]      w_run_len_n;
    logic [PAGE_W-1:0]  w_run_start_n;
    logic               w_hit;
    logic               w_qhit;
    logic               w_pg_we;
    logic [PAGE_W-1:0]  w_pg_waddr;
    logic [ENT_W-1:0]   w_pg_wdata;
    logic               w_clr_pg;
    logic               w_clr_sz;

    assign w_id_ext  = IDX_W'(i_item.alloc_id);
    assign w_in_id   = w_id_ext[ID_BITS-1:0];
    assign w_aid_ext = IDX_W'(r_aid);

    // scan length is the page count clamped to the table size
    assign w_len = (LW'(i_pages_in_use) > LW'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT)
                                                         : CNT_W'(i_pages_in_use);

    assign w_issue    = i_cmd.scan && (r_idx < r_len);
    assign w_tag      = r_rd_ent[ID_BITS-1:0];
    assign w_vld      = r_rd_ent[ID_BITS];
    assign w_active   = i_cmd.scan && r_pend;
    assign w_match    = (w_tag == r_id) && (r_id != '0);
    assign w_free     = (w_tag == '0);
    assign w_is_alloc = (r_func == ffpa_pkg::FN_ALLOC);
    assign w_is_query = (r_func == ffpa_pkg::FN_QUERY);

    assign w_run_len_n   = r_in_run ? (r_run_len + LW'(1)) : LW'(1);
    assign w_run_start_n = r_in_run ? r_run_start : r_rd_idx;

    assign w_hit  = w_active && w_is_alloc && (r_req != '0) && w_free
                  && (w_run_len_n == LW'(r_req));
    assign w_qhit = w_active && w_is_query && w_match;

    assign w_clr_pg = ({1'b0, r_clr} < (CLR_W + 1)'(PAGE_COUNT));
    assign w_clr_sz = ({1'b0, r_clr} < (CLR_W + 1)'(ID_N));

    assign o_stat.clear_last = (r_clr == CLR_W'(CLR_N - 1));
    assign o_stat.scan_end   = w_hit || w_qhit || (r_idx >= r_len);
    assign o_stat.hit        = w_hit;
    assign o_stat.fill_last  = (r_fill_cnt == LW'(1));

    // single write port shared by the clearing sweep, the fill and the scan
    always_comb begin
        w_pg_we    = 1'b0;
        w_pg_waddr = r_rd_idx;
        w_pg_wdata = '0;
        priority if (i_cmd.clear) begin
            w_pg_we    = w_clr_pg;
            w_pg_waddr = r_clr[PAGE_W-1:0];
        end else if (i_cmd.fill) begin
            w_pg_we    = 1'b1;
            w_pg_waddr = r_fill_idx;
            w_pg_wdata = {1'b0, r_aid};
        end else if (w_active && w_match) begin
            unique case (r_func)
                ffpa_pkg::FN_RELEASE: begin
                    w_pg_we = 1'b1;
                end
                ffpa_pkg::FN_SET_VALID: begin
                    w_pg_we    = 1'b1;
                    w_pg_wdata = {1'b1, w_tag};
                end
                ffpa_pkg::FN_CLR_VALID: begin
                    w_pg_we    = 1'b1;
                    w_pg_wdata = {1'b0, w_tag};
                end
                default: begin
                    w_pg_we = 1'b0;
                end
            endcase
        end else begin
            w_pg_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pg_we) begin
            r_page_mem[w_pg_waddr] <= w_pg_wdata;
        end
        if (w_issue) begin
            r_rd_ent <= r_page_mem[r_idx[PAGE_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear && w_clr_sz) begin
            r_size_mem[r_clr[ID_BITS-1:0]] <= '0;
        end else if (i_cmd.load && (i_item.func == ffpa_pkg::FN_ALLOC)) begin
            r_size_mem[r_next_id] <= i_item.req_pages;
        end
        if (i_cmd.load) begin
            r_size_rd <= r_size_mem[w_in_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= ID_BITS'(1);
            r_clr     <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (i_cmd.load) begin
                r_pend <= 1'b0;
                if (i_item.func == ffpa_pkg::FN_ALLOC) begin
                    // id zero is never issued
                    r_next_id <= (r_next_id == '1) ? ID_BITS'(1) : r_next_id + ID_BITS'(1);
                end
            end else if (i_cmd.scan) begin
                r_pend <= w_issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_item.func;
            r_id     <= w_in_id;
            r_req    <= i_item.req_pages;
            r_aid    <= r_next_id;
            r_len    <= w_len;
            r_idx    <= '0;
            r_in_run <= 1'b0;
            r_ok     <= 1'b0;
            r_fv     <= 1'b0;
            r_ex     <= 1'b0;
        end
        if (w_issue) begin
            r_idx    <= r_idx + CNT_W'(1);
            r_rd_idx <= r_idx[PAGE_W-1:0];
        end
        if (w_active && w_is_alloc) begin
            if (w_free) begin
                r_in_run    <= 1'b1;
                r_run_len   <= w_run_len_n;
                r_run_start <= w_run_start_n;
            end else begin
                r_in_run <= 1'b0;
            end
        end
        if (w_hit) begin
            r_ok       <= 1'b1;
            r_fill_idx <= w_run_start_n;
            r_fill_cnt <= LW'(r_req);
        end
        if (w_active && w_match && (r_func == ffpa_pkg::FN_RELEASE)) begin
            r_ok <= 1'b1;
        end
        if (w_qhit) begin
            r_fv <= w_vld;
            r_ex <= 1'b1;
        end
        if (i_cmd.fill) begin
            r_fill_idx <= r_fill_idx + PAGE_W'(1);
            r_fill_cnt <= r_fill_cnt - LW'(1);
        end
    end

    assign o_result.new_id        = w_is_alloc ? w_aid_ext[ffpa_pkg::NEW_ID_W-1:0] : '0;
    assign o_result.ok            = r_ok;
    assign o_result.first_valid   = r_fv;
    assign o_result.id_exists     = r_ex;
    assign o_result.recorded_size = w_is_query ? r_size_rd : '0;

endmodule

/* hw/rtl/first_fit_page_allocator.sv */
// first-fit contiguous page allocator
// command channel: drive i_item and raise start; the item is taken at the clock edge
// where start is high and busy is low. busy stays high until the result has gone out.
// result channel: o_result is presented for a single cycle with o_done high. there is
// no back-pressure, so the result must be captured in that cycle.
// scan, with n = min(pages_in_use, PAGE_COUNT): every operation walks the first n
// entries of the page table once through one memory read port, one entry per cycle. a
// query or a successful allocate stops at its hit; a successful allocate then writes
// its run, one page per cycle.
// reset: a clearing pass sweeps max(PAGE_COUNT, 2^ID_BITS) addresses of the page table
// and the size record, holding busy high; pages_in_use returns to 64 and the id counter
// to 1. the register port takes writes during the pass; reconfigure only while idle.
module first_fit_page_allocator #(
    parameter int PAGE_COUNT = ffpa_pkg::DEF_PAGE_COUNT,
    parameter int ID_BITS    = ffpa_pkg::DEF_ID_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ffpa_pkg::t_in                     i_item,
    output logic                              o_done,
    output ffpa_pkg::t_out                    o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ffpa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ffpa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ffpa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic [ffpa_pkg::CFG_PAGES_W-1:0] r_pages_in_use;
    logic                             w_reg_sel;
    ffpa_pkg::t_cmd                   w_cmd;
    ffpa_pkg::t_stat                  w_stat;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[ffpa_pkg::APB_ADDR_W-1] == ffpa_pkg::REG_PAGES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_in_use <= ffpa_pkg::PAGES_IN_USE_RESET;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_pages_in_use <= pwdata[ffpa_pkg::CFG_PAGES_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? ffpa_pkg::APB_DATA_W'(r_pages_in_use) : '0;

    ffpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ffpa_dp #(
        .PAGE_COUNT (PAGE_COUNT),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_item         (i_item),
        .i_pages_in_use (r_pages_in_use),
        .o_result       (o_result)
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat while not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block not idle after result beat");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted beat did not start an operation");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clear, w_cmd.load, w_cmd.scan, w_cmd.fill}))
        else $error("datapath commands overlap");

endmodule
